// File: rtl/owcg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owcg_pkg
// Shared constants, codes, sine table builder and control structs for the
// ocean wave color generator.
// ----------------------------------------------------------------------------
package owcg_pkg;

    localparam int FRAME_INTERVAL_MS = 33;
    localparam int SINE_TABLE_DEPTH  = 256;
    localparam int PHASE_BITS        = 16;

    localparam int QUAD_SHIFT = PHASE_BITS - 2;
    localparam int LUT_BITS   = $clog2(SINE_TABLE_DEPTH);
    localparam int LUT_SHIFT  = QUAD_SHIFT - LUT_BITS;
    localparam int IDX_BITS   = LUT_BITS + 1;
    localparam int SINE_W     = 15;

    localparam int PHASE_STEP = 13351 >> (24 - PHASE_BITS);
    localparam int ONE_RAD    = 2670177 >> (24 - PHASE_BITS);
    localparam int TWO_RAD    = 5340354 >> (24 - PHASE_BITS);

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // floor(x/10) = (x * RECIP10) >> 23 for x < 2^22
    localparam int RECIP10     = 838861;
    localparam int DIV10_SHIFT = 23;
    // floor(x/5) = (x * RECIP5) >> 20 for x < 2^18
    localparam int RECIP5      = 209716;
    localparam int DIV5_SHIFT  = 20;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_START  = 3'd1;
    localparam logic [2:0] OP_STOP   = 3'd2;
    localparam logic [2:0] OP_PAUSE  = 3'd3;
    localparam logic [2:0] OP_RESUME = 3'd4;

    localparam logic CFG_SPEED          = 1'b0;
    localparam logic CFG_MAX_BRIGHTNESS = 1'b1;

    typedef enum logic [3:0] {
        STEP_IDLE,
        STEP_M13,
        STEP_D13,
        STEP_D7,
        STEP_S1,
        STEP_S2,
        STEP_S3,
        STEP_SB,
        STEP_FIN
    } step_t;

    typedef struct packed {
        logic  clear;
        logic  frame;
        step_t step;
    } cmd_t;

    typedef struct packed {
        logic due;
    } status_t;

    typedef logic [SINE_W-1:0] sine_lut_t [0:SINE_TABLE_DEPTH];

    // Quarter-wave Q1.15 table, Taylor series to x^13 in Q30.
    function automatic sine_lut_t build_sine_lut();
        sine_lut_t       lut;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned v;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++)
        begin
            x    = (longint'(i) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            pos  = x;
            neg  = 0;
            term = ((term * x2) >> 30) / 6;
            neg  = neg + term;
            term = ((term * x2) >> 30) / 20;
            pos  = pos + term;
            term = ((term * x2) >> 30) / 42;
            neg  = neg + term;
            term = ((term * x2) >> 30) / 72;
            pos  = pos + term;
            term = ((term * x2) >> 30) / 110;
            neg  = neg + term;
            term = ((term * x2) >> 30) / 156;
            pos  = pos + term;
            v    = (pos > neg) ? pos - neg : 64'd0;
            v    = (v + 64'd16384) >> 15;
            if (v > 64'd32767)
            begin
                v = 64'd32767;
            end
            lut[i] = v[SINE_W-1:0];
        end
        return lut;
    endfunction

endpackage
`default_nettype wire

// File: rtl/owcg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owcg_ctrl
// Opcode decode, run/pause bookkeeping and frame step sequencer; owns the
// output valid flag.
// ----------------------------------------------------------------------------
module owcg_ctrl
    import owcg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [2:0] in_opcode,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    output cmd_t            cmd,
    input  wire status_t    status
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M13  = 4'd1;
    localparam logic [3:0] S_D13  = 4'd2;
    localparam logic [3:0] S_D7   = 4'd3;
    localparam logic [3:0] S_S1   = 4'd4;
    localparam logic [3:0] S_S2   = 4'd5;
    localparam logic [3:0] S_S3   = 4'd6;
    localparam logic [3:0] S_SB   = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       running_reg, running_next;
    logic       held_reg, held_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        running_next   = running_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.clear      = 1'b0;
        cmd.frame      = 1'b0;
        cmd.step       = STEP_IDLE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_opcode) inside
                        OP_START:
                        begin
                            running_next = 1'b1;
                            held_next    = 1'b0;
                            cmd.clear    = 1'b1;
                        end
                        OP_STOP:
                        begin
                            if (running_reg)
                            begin
                                running_next = 1'b0;
                                held_next    = 1'b0;
                            end
                        end
                        OP_PAUSE, OP_RESUME:
                        begin
                            if (running_reg)
                            begin
                                held_next = (in_opcode == OP_PAUSE);
                            end
                        end
                        OP_TICK:
                        begin
                            if (running_reg && !held_reg && status.due)
                            begin
                                cmd.frame  = 1'b1;
                                state_next = S_M13;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_M13:
            begin
                cmd.step   = STEP_M13;
                state_next = S_D13;
            end
            S_D13:
            begin
                cmd.step   = STEP_D13;
                state_next = S_D7;
            end
            S_D7:
            begin
                cmd.step   = STEP_D7;
                state_next = S_S1;
            end
            S_S1:
            begin
                cmd.step   = STEP_S1;
                state_next = S_S2;
            end
            S_S2:
            begin
                cmd.step   = STEP_S2;
                state_next = S_S3;
            end
            S_S3:
            begin
                cmd.step   = STEP_S3;
                state_next = S_SB;
            end
            S_SB:
            begin
                cmd.step   = STEP_SB;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.step       = STEP_FIN;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            running_reg   <= 1'b0;
            held_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            running_reg   <= running_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// File: rtl/owcg_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owcg_datapath
// Config registers, phase and frame time, shared sine table, wave sum and
// color / brightness / progress mapping into the output register.
// ----------------------------------------------------------------------------
module owcg_datapath
    import owcg_pkg::*;
#(
    parameter int FRAME_GAP_MS = FRAME_INTERVAL_MS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_wdata,
    input  wire logic [31:0] now_ms,
    input  wire cmd_t        cmd,
    output status_t          status,
    output logic [31:0]      out_data
);

    localparam sine_lut_t SINE_LUT = build_sine_lut();

    logic [3:0]            speed_reg;
    logic [6:0]            maxb_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [31:0]           last_frame_reg;
    logic [19:0]           x_reg;
    logic [PHASE_BITS-1:0] arg2_reg;
    logic [PHASE_BITS-1:0] arg3_reg;
    logic signed [20:0]    acc_reg;
    logic [14:0]           quot_reg;
    logic [25:0]           bri_num_reg;
    logic [31:0]           out_data_reg;

    logic [3:0]            spd_sat;
    logic [6:0]            maxb_sat;
    logic [PHASE_BITS-1:0] phase_adv;
    logic [39:0]           div10_prod;
    logic [16:0]           quo10;
    logic [PHASE_BITS-1:0] angle;
    logic [1:0]            quad;
    logic [IDX_BITS-1:0]   idx_raw;
    logic [IDX_BITS-1:0]   idx;
    logic [SINE_W-1:0]     mag;
    logic signed [15:0]    sine_val;
    logic signed [20:0]    s_ext;
    logic signed [19:0]    bri_sum;
    logic [37:0]           div5_prod;
    logic [15:0]           t_val;
    logic                  upper;
    logic [22:0]           g_prod;
    logic [21:0]           b_prod;
    logic [7:0]            g_off;
    logic [7:0]            b_off;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [17:0]           br_prod;
    logic [6:0]            brightness;
    logic [22:0]           prog_prod;
    logic [6:0]            progress;

    assign spd_sat   = (speed_reg == 4'd0) ? 4'd1 :
                       (speed_reg > 4'd10) ? 4'd10 : speed_reg;
    assign maxb_sat  = (maxb_reg > 7'd100) ? 7'd100 : maxb_reg;
    assign phase_adv = phase_reg
                     + PHASE_BITS'(PHASE_BITS'(spd_sat) * PHASE_BITS'(PHASE_STEP));
    assign status.due = (now_ms - last_frame_reg) >= 32'(FRAME_GAP_MS);

    assign div10_prod = 40'(x_reg) * 40'(RECIP10);
    assign quo10      = 17'(div10_prod >> DIV10_SHIFT);

    // shared quarter-wave lookup
    always_comb
    begin
        case (cmd.step)
            STEP_S2: angle = arg2_reg;
            STEP_S3: angle = arg3_reg;
            STEP_SB: angle = phase_reg >> 1;
            default: angle = phase_reg;
        endcase
        quad     = angle[PHASE_BITS-1:PHASE_BITS-2];
        idx_raw  = {1'b0, angle[QUAD_SHIFT-1:LUT_SHIFT]};
        idx      = quad[0] ? IDX_BITS'(SINE_TABLE_DEPTH) - idx_raw : idx_raw;
        mag      = SINE_LUT[idx];
        sine_val = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    assign s_ext     = 21'(sine_val);
    assign bri_sum   = 20'sd229376 + 20'sd3 * 20'(sine_val);
    assign div5_prod = 38'(acc_reg[19:2]) * 38'(RECIP5);

    // both halves of the color map use t = 2*c[13:0]
    assign upper      = quot_reg[14];
    assign t_val      = {quot_reg[13:0], 1'b0};
    assign g_prod     = 23'(t_val) * (upper ? 23'd20 : 23'd80);
    assign b_prod     = 22'(t_val) * 22'd40;
    assign g_off      = 8'(g_prod >> 15);
    assign b_off      = 8'(b_prod >> 15);
    assign green      = upper ? 8'd180 + g_off : 8'd100 + g_off;
    assign blue       = upper ? 8'd220 - b_off : 8'd180 + b_off;
    assign br_prod    = 18'(bri_num_reg[25:16]) * 18'd205;
    assign brightness = 7'(br_prod >> 10);
    assign prog_prod  = 23'(phase_reg) * 23'd100;
    assign progress   = 7'(prog_prod >> PHASE_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg      <= 4'd5;
            maxb_reg       <= 7'd70;
            phase_reg      <= '0;
            last_frame_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SPEED:          speed_reg <= cfg_wdata[3:0];
                    CFG_MAX_BRIGHTNESS: maxb_reg  <= cfg_wdata;
                    default:            speed_reg <= speed_reg;
                endcase
            end
            if (cmd.clear)
            begin
                phase_reg      <= '0;
                last_frame_reg <= '0;
            end
            else if (cmd.frame)
            begin
                phase_reg      <= phase_adv;
                last_frame_reg <= now_ms;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.step)
            STEP_M13:
            begin
                x_reg <= 20'(phase_reg) * 20'd13;
            end
            STEP_D13:
            begin
                arg2_reg <= PHASE_BITS'(quo10) + PHASE_BITS'(ONE_RAD);
                x_reg    <= 20'(phase_reg) * 20'd7;
            end
            STEP_D7:
            begin
                arg3_reg <= PHASE_BITS'(quo10) + PHASE_BITS'(TWO_RAD);
            end
            STEP_S1:
            begin
                acc_reg <= 21'sd5 * s_ext + 21'sd327680;
            end
            STEP_S2:
            begin
                acc_reg <= acc_reg + 21'sd3 * s_ext;
            end
            STEP_S3:
            begin
                acc_reg <= acc_reg + 21'sd2 * s_ext;
            end
            STEP_SB:
            begin
                bri_num_reg <= 26'(maxb_sat) * 26'(bri_sum[18:0]);
                quot_reg    <= 15'(div5_prod >> DIV5_SHIFT);
            end
            STEP_FIN:
            begin
                out_data_reg <= {2'b00, progress, brightness, blue, green};
            end
            default:
            begin
            end
        endcase
    end

    assign out_data = out_data_reg;

endmodule
`default_nettype wire

// File: rtl/ocean_wave_color_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ocean_wave_color_generator
// LED ocean animation: opcode items in, one color frame out per due tick.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries opcode items (tick, start, stop, pause, resume) with the
//   time in ms. A tick while running, not paused and at least FRAME_GAP_MS
//   (33 by default) after the previous frame yields one item on m_axis; all
//   other items give none.
//   cfg_we/cfg_index/cfg_wdata write speed (index 0) and max_brightness
//   (index 1); write only while the block is idle.
//   Sequence: an accepted frame tick runs the steps M13, D13, D7, S1, S2,
//   S3, SB and FIN, and its item shows on m_axis once FIN completes. Items
//   without a frame are accepted back to back; a frame holds tready low while
//   one sine table and one multiply path per step run through the sequence.
//   Reset clears running/paused state, phase and frame time, and sets speed
//   to 5 and max_brightness to 70.
//   Stall: a finished item waits in the output register; the next frame
//   completes its math and then holds, with tready low, until it is taken.
// ----------------------------------------------------------------------------
module ocean_wave_color_generator
    import owcg_pkg::*;
#(
    parameter int FRAME_GAP_MS = FRAME_INTERVAL_MS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // opcode[2:0], now_ms[34:3], zero pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // green[7:0], blue[15:8],
                                             // brightness[22:16], progress[29:23]
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_wdata
);

    cmd_t    cmd;
    status_t status;

    owcg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_opcode (s_axis_tdata[2:0]),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    owcg_datapath
    #(
        .FRAME_GAP_MS (FRAME_GAP_MS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .now_ms    (s_axis_tdata[34:3]),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_axis_tdata)
    );

`ifndef NO_ASSERTIONS
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:0] >= 8'd100) && (m_axis_tdata[7:0] <= 8'd200)
            && (m_axis_tdata[15:8] >= 8'd180) && (m_axis_tdata[15:8] <= 8'd220)
            && (m_axis_tdata[22:16] <= 7'd100) && (m_axis_tdata[29:23] <= 7'd100))
        else $error("output item out of range");

    a_frame_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.frame |-> s_axis_tvalid && s_axis_tready && (s_axis_tdata[2:0] == OP_TICK))
        else $error("frame started without an accepted tick");

    a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step == STEP_FIN) |=> m_axis_tvalid)
        else $error("finished frame not presented");

    a_busy_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.frame |=> !s_axis_tready)
        else $error("input accepted during frame sequence");
`endif

endmodule
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ocean wave color generator. Opcode items are
// streamed in with bursty timing while the output side stalls on its own
// pattern. A local model of the animation (phase, three-sine wave, color map,
// brightness, progress) predicts each frame. Frames are checked field by
// field, in order.
// ----------------------------------------------------------------------------
module tb_top;
    import owcg_pkg::*;

    localparam logic [2:0]  OP_MAX       = 3'd7;
    localparam int          GAP_MS       = 33;
    localparam int          FRAME_STEP   = 52;
    localparam int          ANGLE_1RAD   = 10430;
    localparam int          ANGLE_2RAD   = 20860;
    localparam int          TAB_DEPTH    = 256;
    localparam longint unsigned QTURN_Q30 = 64'd1686629713;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          PRINT_CAP    = 100;

    typedef struct packed {
        logic [6:0] progress;
        logic [6:0] brightness;
        logic [7:0] blue;
        logic [7:0] green;
    } frame_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // opcode[2:0], now_ms[34:3], zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [31:0] m_axis_tdata;        // green[7:0], blue[15:8],
                                      // brightness[22:16], progress[29:23]
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_SPEED;
    logic [6:0]  cfg_wdata = '0;

    // model state
    int unsigned sine_tab [0:TAB_DEPTH];
    logic        run_on;
    logic        on_hold;
    logic [31:0] last_ms;
    logic [15:0] wave_ph;
    logic [3:0]  speed_reg;
    logic [6:0]  maxb_reg;
    frame_t      frames_due [$];

    int          mismatch_count = 0;
    logic [31:0] cur_ms = '0;
    bit          sender_eager = 1'b0;
    int          burst_left = 0;

    // receiver side
    int          hold_request = 0;
    int          hold_left = 0;
    int          ready_mode = 0;
    int          stall_run = 0;
    int          rx_cycle = 0;

    ocean_wave_color_generator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #10 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint expv,
                                   input longint gotv);
        if (mismatch_count < PRINT_CAP)
        begin
            $display("ERROR @%0t: %s expected %0d got %0d", $time, what, expv, gotv);
        end
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Animation model
    // ------------------------------------------------------------------
    function automatic void build_sine_tab();
        longint unsigned x, x2, term, pos, neg, v;
        for (int i = 0; i <= TAB_DEPTH; i++)
        begin
            x    = (longint'(i) * QTURN_Q30) / TAB_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            pos  = x;
            neg  = 0;
            for (int k = 1; k <= 6; k++)
            begin
                term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                    neg += term;
                else
                    pos += term;
            end
            v = (pos > neg) ? pos - neg : 0;
            v = (v + 16384) >> 15;
            if (v > 32767)
                v = 32767;
            sine_tab[i] = int'(v);
        end
    endfunction

    function automatic int wave_sine(input logic [15:0] ang);
        int idx;
        int v;
        idx = int'(ang[13:6]);
        if (ang[14])
            idx = TAB_DEPTH - idx;
        v = int'(sine_tab[idx]);
        return ang[15] ? -v : v;
    endfunction

    function automatic frame_t render_frame(input logic [15:0] ph, input int maxb);
        frame_t      f;
        int unsigned a2, a3;
        int          s1, s2, s3, sb, c, t;
        longint      br;
        a2 = (int'(ph) * 13) / 10 + ANGLE_1RAD;
        a3 = (int'(ph) * 7) / 10 + ANGLE_2RAD;
        s1 = wave_sine(ph);
        s2 = wave_sine(a2[15:0]);
        s3 = wave_sine(a3[15:0]);
        sb = wave_sine({1'b0, ph[15:1]});
        c  = (5 * s1 + 3 * s2 + 2 * s3 + 327680) / 20;
        if (c < 16384)
        begin
            t = 2 * c;
            f.green = 8'(100 + (t * 80) / 32768);
            f.blue  = 8'(180 + (t * 40) / 32768);
        end
        else
        begin
            t = 2 * (c - 16384);
            f.green = 8'(180 + (t * 20) / 32768);
            f.blue  = 8'(220 - (t * 40) / 32768);
        end
        br = (longint'(maxb) * (229376 + 3 * longint'(sb))) / 327680;
        f.brightness = 7'(br);
        f.progress   = 7'((int'(ph) * 100) >> 16);
        return f;
    endfunction

    task automatic advance_animation(input logic [2:0] op, input logic [31:0] ms);
        int          spd;
        int          maxb;
        logic [31:0] elapsed;
        case (op)
            OP_START:
            begin
                run_on  = 1'b1;
                on_hold = 1'b0;
                last_ms = '0;
                wave_ph = '0;
            end
            OP_STOP:
            begin
                if (run_on)
                begin
                    run_on  = 1'b0;
                    on_hold = 1'b0;
                end
            end
            OP_PAUSE, OP_RESUME:
            begin
                if (run_on)
                    on_hold = (op == OP_PAUSE);
            end
            OP_TICK:
            begin
                elapsed = ms - last_ms;
                if (run_on && !on_hold && elapsed >= GAP_MS)
                begin
                    last_ms = ms;
                    spd  = (speed_reg == 0) ? 1 : (speed_reg > 10) ? 10 : int'(speed_reg);
                    maxb = (maxb_reg > 100) ? 100 : int'(maxb_reg);
                    wave_ph = wave_ph + 16'(spd * FRAME_STEP);
                    frames_due.push_back(render_frame(wave_ph, maxb));
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stream driver, config writes, drain
    // ------------------------------------------------------------------
    task automatic send_item(input logic [2:0] op, input logic [31:0] ms);
        int gap;
        if (!sender_eager)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20)
                                                  : $urandom_range(1, 4);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left--;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, ms, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        advance_animation(op, ms);
    endtask

    task automatic send_tick(input int unsigned lo, input int unsigned hi);
        cur_ms = cur_ms + $urandom_range(lo, hi);
        send_item(OP_TICK, cur_ms);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [6:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (idx == CFG_SPEED)
            speed_reg = val[3:0];
        else
            maxb_reg = val;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: stall patterns and a long hold on request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rx_cycle++;
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (rx_cycle % 200 == 0)
                ready_mode = $urandom_range(0, 3);
            case (ready_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2: m_axis_tready <= ((rx_cycle % 7) >= 3);
                default:
                begin
                    if (stall_run > 0)
                    begin
                        stall_run--;
                        m_axis_tready <= 1'b0;
                    end
                    else if ($urandom_range(0, 15) == 0)
                    begin
                        stall_run = $urandom_range(3, 15);
                        m_axis_tready <= 1'b0;
                    end
                    else
                    begin
                        m_axis_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        frame_t got;
        frame_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = frame_t'(m_axis_tdata[29:0]);
            if (frames_due.size() == 0)
            begin
                report_mismatch("unexpected frame, tdata", 0, m_axis_tdata);
            end
            else
            begin
                want = frames_due.pop_front();
                if (got.green != want.green)
                    report_mismatch("green", want.green, got.green);
                if (got.blue != want.blue)
                    report_mismatch("blue", want.blue, got.blue);
                if (got.brightness != want.brightness)
                    report_mismatch("brightness", want.brightness, got.brightness);
                if (got.progress != want.progress)
                    report_mismatch("progress", want.progress, got.progress);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_opcodes_and_timing();
        send_item(OP_TICK, 32'd100);         // not running
        send_item(OP_STOP, $urandom());
        send_item(OP_PAUSE, $urandom());
        send_item(OP_RESUME, $urandom());
        send_item(OP_START, 32'hFFFF_FFFF);
        send_item(OP_TICK, 32'd32);          // one ms early
        send_item(OP_TICK, 32'd33);
        send_item(OP_TICK, 32'd65);
        send_item(OP_TICK, 32'd66);
        send_item(OP_PAUSE, $urandom());
        send_item(OP_TICK, 32'd200);         // paused
        send_item(OP_PAUSE, $urandom());
        send_item(OP_RESUME, $urandom());
        send_item(OP_TICK, 32'd200);
        send_item(3'd5, $urandom());
        send_item(3'd6, $urandom());
        send_item(OP_MAX, $urandom());
        send_item(OP_TICK, 32'hFFFF_FFE0);
        send_item(OP_TICK, 32'hFFFF_FFFF);   // 31 ms later
        send_item(OP_TICK, 32'h0000_0001);   // spacing wraps to 33
        send_item(OP_START, 32'd0);          // restart while running
        send_item(OP_TICK, 32'd0);
        send_item(OP_TICK, 32'hFFFF_FFFF);
        send_item(OP_STOP, 32'd0);
        send_item(OP_RESUME, $urandom());    // ignored while stopped
        send_item(OP_TICK, 32'h8000_0000);
        settle();
    endtask

    task automatic test_config_extremes();
        logic [6:0] spd_set [7] = '{7'd0, 7'd1, 7'd10, 7'd15, 7'd11, 7'd127, 7'd5};
        logic [6:0] maxb_set [7] = '{7'd0, 7'd1, 7'd100, 7'd127, 7'd101, 7'd64, 7'd70};
        for (int n = 0; n < 7; n++)
        begin
            settle();
            cfg_write(CFG_SPEED, spd_set[n]);
            cfg_write(CFG_MAX_BRIGHTNESS, maxb_set[n]);
            cur_ms = $urandom_range(33, 1000);
            send_item(OP_START, $urandom());
            send_item(OP_TICK, cur_ms);
            repeat (12) send_tick(33, 45);
        end
        settle();
    endtask

    task automatic test_phase_wrap();
        cfg_write(CFG_SPEED, 7'd10);
        cfg_write(CFG_MAX_BRIGHTNESS, 7'd100);
        sender_eager = 1'b1;
        send_item(OP_START, $urandom());
        cur_ms = 32'hFFFF_0000;
        repeat (140) send_tick(33, 33);
        sender_eager = 1'b0;
        settle();
    endtask

    task automatic test_backpressure();
        hold_request = 300;
        sender_eager = 1'b1;
        send_item(OP_START, $urandom());
        cur_ms = $urandom();
        repeat (30) send_tick(40, 60);
        sender_eager = 1'b0;
        settle();
    endtask

    task automatic test_random_traffic();
        int         r;
        logic [2:0] op;
        for (int n = 0; n < 700; n++)
        begin
            if (n % 175 == 0)
            begin
                settle();
                cfg_write(CFG_SPEED, 7'($urandom_range(0, 127)));
                cfg_write(CFG_MAX_BRIGHTNESS, 7'($urandom_range(0, 127)));
                sender_eager = ($urandom_range(0, 2) == 0);
            end
            r = $urandom_range(0, 999);
            if (!run_on && $urandom_range(0, 3) == 0)
            begin
                send_item(OP_START, $urandom());
            end
            else if (r < 780)
            begin
                case ($urandom_range(0, 19))
                    0:
                    begin
                        cur_ms = $urandom();
                        send_item(OP_TICK, cur_ms);
                    end
                    1, 2, 3: send_tick(0, 32);
                    default: send_tick(33, 70);
                endcase
            end
            else
            begin
                if (r < 820)
                    op = OP_PAUSE;
                else if (r < 900)
                    op = OP_RESUME;
                else if (r < 915)
                    op = OP_STOP;
                else if (r < 925)
                    op = OP_START;
                else
                    op = 3'($urandom_range(OP_RESUME + 1, OP_MAX));
                send_item(op, $urandom());
            end
        end
        sender_eager = 1'b0;
        settle();
    endtask

    initial
    begin
        build_sine_tab();
        run_on    = 1'b0;
        on_hold   = 1'b0;
        last_ms   = '0;
        wave_ph   = '0;
        speed_reg = 4'd5;
        maxb_reg  = 7'd70;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_opcodes_and_timing();
        test_config_extremes();
        test_phase_wrap();
        test_backpressure();
        test_random_traffic();

        if (frames_due.size() != 0)
            report_mismatch("frames never produced", frames_due.size(), 0);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: ocean_wave_color_generator.f
rtl/owcg_pkg.sv
rtl/owcg_ctrl.sv
rtl/owcg_datapath.sv
rtl/ocean_wave_color_generator.sv
test/tb_top.sv
